// ===== src/ftg_pkg.sv =====
// ----------------------------------------------------------------------------
// ftg_pkg
// Shared constants and types for the frame time target governor.
// ----------------------------------------------------------------------------
package ftg_pkg;

  localparam int DATA_W     = 24;
  localparam int WINDOW_DEF = 16;
  localparam int CFG_IDX_W  = 3;

  typedef logic [DATA_W-1:0] us_t;

  // Reset values
  localparam us_t TARGET_RESET     = 24'd16667;
  localparam us_t MAX_ADJUST_RST   = 24'd1000;
  localparam us_t MAX_FRAME_RST    = 24'd100000;
  localparam us_t REMOTE_FLOOR_RST = 24'd33333;
  localparam us_t MIN_FRAME_RST    = 24'd2000;

  // floor(x/10) == (x * RECIP_M) >> RECIP_SHIFT for any 24-bit x
  localparam int  RECIP_SHIFT = 27;
  localparam us_t RECIP_M     = 24'd13421773;

  // Register indexes on the config port
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MAX_ADJUST     = 3'd0,
    REG_MAX_FRAME_TIME = 3'd1,
    REG_REMOTE_FLOOR   = 3'd2,
    REG_MIN_FRAME_TIME = 3'd3,
    REG_REMOTE_MODE    = 3'd4,
    REG_FPS_UNLOCKED   = 3'd5
  } cfg_idx_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DIV,
    ST_GOAL,
    ST_STEP,
    ST_APPLY,
    ST_FLOOR,
    ST_OUT
  } state_t;

endpackage

// ===== src/frame_time_target_governor.sv =====
// ----------------------------------------------------------------------------
// frame_time_target_governor
// Keeps a ring of recent frame intervals and steers a target frame time
// toward a goal set by the window's spread, then applies the floors.
// ----------------------------------------------------------------------------
//  channel  dir  handshake            payload
//  in       in   in_valid / in_stall   interval_us  [23:0]
//  out      out  out_valid / out_stall target_us    [23:0]
//  cfg      in   cfg_we                cfg_index [2:0], cfg_data [23:0]
//
// One item at a time. While the ring is filling (first WINDOW+1 beats) an item goes
// straight to the floors; afterwards it first runs the min/max scan through the ring
// RAM's single read port, one entry a cycle. A new beat is taken as soon as the
// previous result sits in the output register. Reset is synchronous; the ring needs
// no clearing, it is always fully written before the first scan. A stalled output
// holds its beat; the next result waits in ST_OUT, taking no new beat, until hand-off.
// ----------------------------------------------------------------------------
module frame_time_target_governor #(
  parameter int WINDOW = ftg_pkg::WINDOW_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [ftg_pkg::DATA_W-1:0]     interval_us,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [ftg_pkg::DATA_W-1:0]     target_us,
  input  logic                           cfg_we,
  input  logic [ftg_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [ftg_pkg::DATA_W-1:0]     cfg_data
);

  localparam int AW = $clog2(WINDOW);
  localparam int CW = $clog2(WINDOW + 1);
  localparam int FW = $clog2(WINDOW + 2);
  localparam int DW = ftg_pkg::DATA_W;
  localparam int QW = 2 * DW - ftg_pkg::RECIP_SHIFT;

  // Config registers
  ftg_pkg::us_t max_adjust;
  ftg_pkg::us_t max_frame_time;
  ftg_pkg::us_t remote_floor;
  ftg_pkg::us_t min_frame_time;
  logic         remote_mode;
  logic         fps_unlocked;

  ftg_pkg::state_t state, state_next;

  logic [AW-1:0]   write_slot;
  logic [FW-1:0]   fill_count;
  logic [CW-1:0]   cnt;
  logic            rd_vld;
  ftg_pkg::us_t    target_time;
  ftg_pkg::us_t    hi, lo;
  ftg_pkg::us_t    rd_data;
  logic [2*DW-1:0] prod;
  ftg_pkg::us_t    goal;
  logic signed [DW:0]   step;

  logic in_acc, out_acc, out_load, filled, scan_done;
  logic signed [DW:0]   gap, half, lim, step_next;
  logic signed [DW+1:0] t_sum;
  ftg_pkg::us_t         t_cap, t_floor;

  assign in_acc    = in_valid && !in_stall;
  assign out_acc   = out_valid && !out_stall;
  assign filled    = (fill_count > FW'(WINDOW));
  assign scan_done = (cnt == CW'(WINDOW));

  // ---------------- config ----------------
  always_ff @(posedge clk) begin
    if (rst) begin
      max_adjust     <= ftg_pkg::MAX_ADJUST_RST;
      max_frame_time <= ftg_pkg::MAX_FRAME_RST;
      remote_floor   <= ftg_pkg::REMOTE_FLOOR_RST;
      min_frame_time <= ftg_pkg::MIN_FRAME_RST;
      remote_mode    <= 1'b0;
      fps_unlocked   <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        ftg_pkg::REG_MAX_ADJUST:     max_adjust     <= cfg_data;
        ftg_pkg::REG_MAX_FRAME_TIME: max_frame_time <= cfg_data;
        ftg_pkg::REG_REMOTE_FLOOR:   remote_floor   <= cfg_data;
        ftg_pkg::REG_MIN_FRAME_TIME: min_frame_time <= cfg_data;
        ftg_pkg::REG_REMOTE_MODE:    remote_mode    <= cfg_data[0];
        ftg_pkg::REG_FPS_UNLOCKED:   fps_unlocked   <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // ---------------- ring memory ----------------
  ftg_ram #(
    .WIDTH (DW),
    .DEPTH (WINDOW)
  ) u_ring (
    .clk   (clk),
    .we    (in_acc),
    .waddr (write_slot),
    .wdata (interval_us),
    .raddr (cnt[AW-1:0]),
    .rdata (rd_data)
  );

  // ---------------- FSM ----------------
  always_comb begin
    state_next = state;
    unique case (state)
      ftg_pkg::ST_IDLE:  if (in_acc) state_next = filled ? ftg_pkg::ST_SCAN : ftg_pkg::ST_FLOOR;
      ftg_pkg::ST_SCAN:  if (scan_done) state_next = ftg_pkg::ST_DIV;
      ftg_pkg::ST_DIV:   state_next = ftg_pkg::ST_GOAL;
      ftg_pkg::ST_GOAL:  state_next = ftg_pkg::ST_STEP;
      ftg_pkg::ST_STEP:  state_next = ftg_pkg::ST_APPLY;
      ftg_pkg::ST_APPLY: state_next = ftg_pkg::ST_FLOOR;
      ftg_pkg::ST_FLOOR: state_next = ftg_pkg::ST_OUT;
      ftg_pkg::ST_OUT:   if (!out_valid || !out_stall) state_next = ftg_pkg::ST_IDLE;
      default:           state_next = ftg_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_stall = (state != ftg_pkg::ST_IDLE);
    out_load = (state == ftg_pkg::ST_OUT) && (!out_valid || !out_stall);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ftg_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // ---------------- datapath arithmetic ----------------
  always_comb begin
    gap  = $signed({1'b0, goal}) - $signed({1'b0, target_time});
    half = gap >>> 1;
    if (gap[DW] && gap[0]) begin
      half = half + (DW+1)'(1);   // round toward zero
    end
    lim = $signed({1'b0, max_adjust});
    if (half > lim) begin
      step_next = lim;
    end else if (half < -lim) begin
      step_next = -lim;
    end else begin
      step_next = half;
    end

    t_sum = $signed({2'b00, target_time}) + (DW+2)'(step);
    if (t_sum < 0) begin
      t_cap = '0;
    end else if (t_sum > $signed({2'b00, max_frame_time})) begin
      t_cap = max_frame_time;
    end else begin
      t_cap = t_sum[DW-1:0];
    end

    t_floor = target_time;
    if (remote_mode && t_floor < remote_floor) begin
      t_floor = remote_floor;
    end
    if (!fps_unlocked && t_floor < min_frame_time) begin
      t_floor = min_frame_time;
    end
  end

  // ---------------- control state ----------------
  always_ff @(posedge clk) begin
    if (rst) begin
      write_slot  <= '0;
      fill_count  <= '0;
      cnt         <= '0;
      rd_vld      <= 1'b0;
      target_time <= ftg_pkg::TARGET_RESET;
      out_valid   <= 1'b0;
    end else begin
      rd_vld <= (state == ftg_pkg::ST_SCAN) && !scan_done;
      if (in_acc) begin
        write_slot <= (write_slot == AW'(WINDOW - 1)) ? '0 : write_slot + AW'(1);
        if (!filled) begin
          fill_count <= fill_count + FW'(1);
        end
        cnt <= '0;
      end else if (state == ftg_pkg::ST_SCAN && !scan_done) begin
        cnt <= cnt + CW'(1);
      end
      if (state == ftg_pkg::ST_APPLY) begin
        target_time <= t_cap;
      end else if (state == ftg_pkg::ST_FLOOR) begin
        target_time <= t_floor;
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_acc) begin
        out_valid <= 1'b0;
      end
    end
  end

  // ---------------- payload registers ----------------
  always_ff @(posedge clk) begin
    if (in_acc) begin
      hi <= '0;
      lo <= '1;
    end else if (rd_vld) begin
      if (rd_data > hi) hi <= rd_data;
      if (rd_data < lo) lo <= rd_data;
    end
    if (state == ftg_pkg::ST_DIV) begin
      // tenth via reciprocal
      prod <= (2*DW)'(hi - lo) * (2*DW)'(ftg_pkg::RECIP_M);
    end
    if (state == ftg_pkg::ST_GOAL) begin
      goal <= hi - DW'(prod[2*DW-1 -: QW]);
    end
    if (state == ftg_pkg::ST_STEP) begin
      step <= step_next;
    end
    if (out_load) begin
      target_us <= target_time;
    end
  end

  // ---------------- assertions ----------------
  a_fill_sat: assert property (@(posedge clk) disable iff (rst)
    fill_count <= FW'(WINDOW + 1))
    else $error("fill count past saturation");

  a_scan_after_fill: assert property (@(posedge clk) disable iff (rst)
    in_acc && filled |=> state == ftg_pkg::ST_SCAN)
    else $error("filled ring did not start a scan");

  a_fill_skips_scan: assert property (@(posedge clk) disable iff (rst)
    in_acc && !filled |=> state == ftg_pkg::ST_FLOOR)
    else $error("filling beat entered the adjust path");

  a_rd_in_scan: assert property (@(posedge clk) disable iff (rst)
    rd_vld |-> state == ftg_pkg::ST_SCAN)
    else $error("ring read data outside scan");

  a_min_floor: assert property (@(posedge clk) disable iff (rst)
    out_load && !fps_unlocked |=> target_us >= min_frame_time)
    else $error("result below minimum frame time");

endmodule

// ===== src/ftg_ram.sv =====
// ----------------------------------------------------------------------------
// ftg_ram
// Simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module ftg_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
